// File: design/gpr_pkg.sv
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared widths, register codes, stage types and kernel helpers for the
// 5x5 binomial pyramid reduce stage.
// ----------------------------------------------------------------------------
package gpr_pkg;

   localparam int PIXEL_W      = 8;
   localparam int OUT_X_W      = 9;
   localparam int OUT_Y_W      = 11;
   localparam int SRC_WIDTH_W  = 11;
   localparam int SRC_HEIGHT_W = 12;
   localparam int ROW_W        = 12;
   localparam int VSUM_W       = 12;
   localparam int HSUM_W       = 16;
   localparam int SLOTS        = 4;
   localparam int SLOT_W       = 2;
   localparam int OFS_W        = 3;

   localparam int MIN_DIM      = 4;
   localparam int WIDTH_RESET  = 320;
   localparam int HEIGHT_RESET = 240;

   localparam logic [OFS_W-1:0] OFS_MAX = 3'd4;
   localparam int TAPS = 5;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register index, taken from paddr[2]
   localparam logic REG_SRC_WIDTH  = 1'b0;
   localparam logic REG_SRC_HEIGHT = 1'b1;

   typedef struct packed {
      logic                    restart;
      logic [SRC_WIDTH_W-1:0]  width;
      logic [SRC_HEIGHT_W-1:0] height;
   } csr_cfg_type;

   // per-word position info, carried along the pipeline
   typedef struct packed {
      logic               emit;
      logic               done;
      logic               last_r_even;
      logic               last_c_even;
      logic [OFS_W-1:0]   r_min;
      logic [SLOT_W-1:0]  r_lo;
      logic [OFS_W-1:0]   c_min;
      logic [OUT_X_W-1:0] out_x;
      logic [OUT_Y_W-1:0] out_y;
   } pos_info_type;

   typedef logic [SLOTS-1:0][PIXEL_W-1:0] line_word_type;

   // Offset back from the newest sample for tap k. On the last row or column
   // of an even-sized image the window is centred one later and the far edge
   // repeats the newest sample.
   function automatic logic [OFS_W-1:0] tap_offset(input logic [OFS_W-1:0] k,
                                                   input logic last_even);
      logic [OFS_W-1:0] j;
      if (last_even) begin
         j = (k >= OFS_MAX) ? 3'd0 : 3'd3 - k;
      end else begin
         j = OFS_MAX - k;
      end
      return j;
   endfunction

   // edge clamp: never reach back past position zero
   function automatic logic [OFS_W-1:0] clip_offset(input logic [OFS_W-1:0] j,
                                                    input logic [OFS_W-1:0] lim);
      return (j > lim) ? lim : j;
   endfunction

   // 1 4 6 4 1 weighted sum, shifts and adds only
   function automatic logic [HSUM_W-1:0] binom5(input logic [VSUM_W-1:0] a,
                                                input logic [VSUM_W-1:0] b,
                                                input logic [VSUM_W-1:0] c,
                                                input logic [VSUM_W-1:0] d,
                                                input logic [VSUM_W-1:0] e);
      logic [HSUM_W-1:0] xa;
      logic [HSUM_W-1:0] xb;
      logic [HSUM_W-1:0] xc;
      logic [HSUM_W-1:0] xd;
      logic [HSUM_W-1:0] xe;
      xa = HSUM_W'(a);
      xb = HSUM_W'(b);
      xc = HSUM_W'(c);
      xd = HSUM_W'(d);
      xe = HSUM_W'(e);
      return xa + (xb << 2) + (xc << 2) + (xc << 1) + (xd << 2) + xe;
   endfunction

endpackage

// File: design/gpr_req_if.sv
// ----------------------------------------------------------------------------
// gpr_req_if
// Source pixel stream: valid/ready handshake, one pixel per word.
// ----------------------------------------------------------------------------
interface gpr_req_if;
   logic                        valid;
   logic                        ready;
   logic [gpr_pkg::PIXEL_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

// File: design/gpr_rsp_if.sv
// ----------------------------------------------------------------------------
// gpr_rsp_if
// Reduced pixel stream: valid/ready handshake, pixel with its coordinates.
// ----------------------------------------------------------------------------
interface gpr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gpr_pkg::PIXEL_W-1:0] out_pixel;
   logic [gpr_pkg::OUT_X_W-1:0] out_x;
   logic [gpr_pkg::OUT_Y_W-1:0] out_y;
   logic                        frame_done;

   modport source (output valid, output out_pixel, output out_x, output out_y,
                   output frame_done, input ready);
   modport sink   (input valid, input out_pixel, input out_x, input out_y,
                   input frame_done, output ready);
endinterface

// File: design/gpr_csr.sv
// ----------------------------------------------------------------------------
// gpr_csr
// APB-style register block: source width and height. A write to either
// register restarts the frame.
// ----------------------------------------------------------------------------
module gpr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [gpr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gpr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gpr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output gpr_pkg::csr_cfg_type             cfg
);

   logic [gpr_pkg::SRC_WIDTH_W-1:0]  width_ff, width_in;
   logic [gpr_pkg::SRC_HEIGHT_W-1:0] height_ff, height_in;
   logic                             wr;
   logic                             idx;

   assign wr  = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_paddr[2];
   assign csr_pready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr) begin
         unique case (idx)
            gpr_pkg::REG_SRC_WIDTH: begin
               width_in = csr_pwdata[gpr_pkg::SRC_WIDTH_W-1:0];
            end
            gpr_pkg::REG_SRC_HEIGHT: begin
               height_in = csr_pwdata[gpr_pkg::SRC_HEIGHT_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= gpr_pkg::SRC_WIDTH_W'(gpr_pkg::WIDTH_RESET);
         height_ff <= gpr_pkg::SRC_HEIGHT_W'(gpr_pkg::HEIGHT_RESET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (idx)
         gpr_pkg::REG_SRC_WIDTH:  csr_prdata = gpr_pkg::CSR_DATA_W'(width_ff);
         gpr_pkg::REG_SRC_HEIGHT: csr_prdata = gpr_pkg::CSR_DATA_W'(height_ff);
      endcase
   end

   // restart lands on the same edge as the write
   assign cfg.restart = wr;
   assign cfg.width   = width_ff;
   assign cfg.height  = height_ff;

endmodule

// File: design/gpr_line_store.sv
// ----------------------------------------------------------------------------
// gpr_line_store
// Four-row line memory (one word per column, one byte lane per row slot)
// and the vertical 5-tap sum stage.
// ----------------------------------------------------------------------------
module gpr_line_store #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic                             advance,
   input  logic [$clog2(MAX_WIDTH)-1:0]     col_addr,
   input  logic [gpr_pkg::PIXEL_W-1:0]      pixel,
   input  gpr_pkg::pos_info_type            pos_info,
   output logic                             s2_valid,
   output logic [gpr_pkg::VSUM_W-1:0]       s2_vsum,
   output gpr_pkg::pos_info_type            s2_info
);

   gpr_pkg::line_word_type line_rows_mem [MAX_WIDTH];
   gpr_pkg::line_word_type rd_ff;

   logic                          s1_valid_ff, s1_valid_in;
   logic [gpr_pkg::PIXEL_W-1:0]   s1_pix_ff, s1_pix_in;
   gpr_pkg::pos_info_type         s1_info_ff, s1_info_in;
   logic                          s2_valid_ff, s2_valid_in;
   logic [gpr_pkg::VSUM_W-1:0]    s2_vsum_ff, s2_vsum_in;
   gpr_pkg::pos_info_type         s2_info_ff, s2_info_in;

   logic [gpr_pkg::VSUM_W-1:0]    tap_val [gpr_pkg::TAPS];
   logic [gpr_pkg::VSUM_W-1:0]    vsum;

   // read returns the old word; the slot written now held row r-4
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_rows_mem[col_addr];
         line_rows_mem[col_addr][pos_info.r_lo] <= pixel;
      end
   end

   always_comb begin
      logic [gpr_pkg::OFS_W-1:0]  e;
      logic [gpr_pkg::SLOT_W-1:0] slot;
      for (int k = 0; k < gpr_pkg::TAPS; k++) begin
         e = gpr_pkg::clip_offset(gpr_pkg::tap_offset(gpr_pkg::OFS_W'(k),
                                                      s1_info_ff.last_r_even),
                                  s1_info_ff.r_min);
         slot = s1_info_ff.r_lo - gpr_pkg::SLOT_W'(e);
         if (e == '0) begin
            tap_val[k] = gpr_pkg::VSUM_W'(s1_pix_ff);
         end else begin
            tap_val[k] = gpr_pkg::VSUM_W'(rd_ff[slot]);
         end
      end
      vsum = gpr_pkg::VSUM_W'(gpr_pkg::binom5(tap_val[0], tap_val[1], tap_val[2],
                                              tap_val[3], tap_val[4]));
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_pix_in   = s1_pix_ff;
      s1_info_in  = s1_info_ff;
      s2_valid_in = s2_valid_ff;
      s2_vsum_in  = s2_vsum_ff;
      s2_info_in  = s2_info_ff;
      if (advance) begin
         s1_valid_in = accept;
         s2_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            s2_vsum_in = vsum;
            s2_info_in = s1_info_ff;
         end
      end
      if (accept) begin
         s1_pix_in  = pixel;
         s1_info_in = pos_info;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_pix_ff  <= s1_pix_in;
      s1_info_ff <= s1_info_in;
      s2_vsum_ff <= s2_vsum_in;
      s2_info_ff <= s2_info_in;
   end

   assign s2_valid = s2_valid_ff;
   assign s2_vsum  = s2_vsum_ff;
   assign s2_info  = s2_info_ff;

endmodule

// File: design/gpr_hsum.sv
// ----------------------------------------------------------------------------
// gpr_hsum
// Column-sum history, horizontal 5-tap sum, scaling and the output register.
// ----------------------------------------------------------------------------
module gpr_hsum (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        restart,
   input  logic                        advance,
   input  logic                        s2_valid,
   input  logic [gpr_pkg::VSUM_W-1:0]  s2_vsum,
   input  gpr_pkg::pos_info_type       s2_info,
   gpr_rsp_if.source                   rsp
);

   // most recent column first
   logic [gpr_pkg::VSUM_W-1:0]  cs_ff [gpr_pkg::SLOTS];
   logic [gpr_pkg::VSUM_W-1:0]  cs_in [gpr_pkg::SLOTS];

   logic                        valid_ff, valid_in;
   logic [gpr_pkg::PIXEL_W-1:0] pix_ff, pix_in;
   logic [gpr_pkg::OUT_X_W-1:0] x_ff, x_in;
   logic [gpr_pkg::OUT_Y_W-1:0] y_ff, y_in;
   logic                        done_ff, done_in;

   logic [gpr_pkg::VSUM_W-1:0]  tap_val [gpr_pkg::TAPS];
   logic [gpr_pkg::HSUM_W-1:0]  hsum;
   logic                        take;

   assign take = advance & s2_valid;

   always_comb begin
      logic [gpr_pkg::OFS_W-1:0] e;
      for (int k = 0; k < gpr_pkg::TAPS; k++) begin
         e = gpr_pkg::clip_offset(gpr_pkg::tap_offset(gpr_pkg::OFS_W'(k),
                                                      s2_info.last_c_even),
                                  s2_info.c_min);
         if (e == '0) begin
            tap_val[k] = s2_vsum;
         end else begin
            tap_val[k] = cs_ff[gpr_pkg::SLOT_W'(e - 3'd1)];
         end
      end
      hsum = gpr_pkg::binom5(tap_val[0], tap_val[1], tap_val[2], tap_val[3], tap_val[4]);
   end

   always_comb begin
      cs_in = cs_ff;
      if (restart) begin
         for (int i = 0; i < gpr_pkg::SLOTS; i++) begin
            cs_in[i] = '0;
         end
      end else if (take) begin
         for (int i = gpr_pkg::SLOTS - 1; i > 0; i--) begin
            cs_in[i] = cs_ff[i-1];
         end
         cs_in[0] = s2_vsum;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      pix_in   = pix_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      done_in  = done_ff;
      if (advance) begin
         valid_in = take & s2_info.emit;
      end
      if (take && s2_info.emit) begin
         pix_in  = hsum[gpr_pkg::HSUM_W-1 -: gpr_pkg::PIXEL_W];
         x_in    = s2_info.out_x;
         y_in    = s2_info.out_y;
         done_in = s2_info.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < gpr_pkg::SLOTS; i++) begin
            cs_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         cs_ff    <= cs_in;
      end
      pix_ff  <= pix_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      done_ff <= done_in;
   end

   assign rsp.valid      = valid_ff;
   assign rsp.out_pixel  = pix_ff;
   assign rsp.out_x      = x_ff;
   assign rsp.out_y      = y_ff;
   assign rsp.frame_done = done_ff;

endmodule

// File: design/gaussian_pyramid_reduce.sv
// ----------------------------------------------------------------------------
// gaussian_pyramid_reduce
// One 2x reduce level: 5x5 binomial blur with edge clamp, then decimation.
// ----------------------------------------------------------------------------
// Usage:
//   req carries source pixels in raster order, one word per pixel. rsp carries
//   one word per reduced pixel with its column, row and an end-of-frame flag.
//   src_width (addr 0) and src_height (addr 4) are set over the csr_ port while
//   the block is idle; either write restarts the frame at pixel (0,0).
// Throughput: one pixel per clock, sustained while rsp does not stall.
// Pipeline: the pixel that completes a window is registered with its line read,
//   then its vertical sum, then its horizontal sum in the rsp output register.
// Storage: one MAX_WIDTH x 32-bit line memory, one byte lane per row slot,
//   read and written at the same column in the cycle a pixel is taken; the
//   column is revisited only one row later, so no forwarding is needed.
// Stall: while a result word waits on rsp, the whole pipeline holds and req
//   ready drops; nothing is lost or repeated.
// Reset: registers go to 320 x 240, position to (0,0), column history to zero.
//   The line memory is not cleared: every read in a frame hits a row that was
//   written earlier in that frame.
// ----------------------------------------------------------------------------
module gaussian_pyramid_reduce #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   gpr_req_if.sink                          req,
   gpr_rsp_if.source                        rsp,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [gpr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gpr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gpr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WE = CW + 1;
   localparam int WX = (WE > gpr_pkg::SRC_WIDTH_W) ? WE : gpr_pkg::SRC_WIDTH_W;

   gpr_pkg::csr_cfg_type  cfg;
   gpr_pkg::pos_info_type pos_info;
   gpr_pkg::pos_info_type s2_info;
   logic                  s2_valid;
   logic [gpr_pkg::VSUM_W-1:0] s2_vsum;

   logic [CW-1:0]             col_ff, col_in;
   logic [gpr_pkg::ROW_W-1:0] row_ff, row_in;

   logic [WX-1:0]             w_raw;
   logic [WE-1:0]             w_eff;
   logic [CW-1:0]             w_last;
   logic [gpr_pkg::ROW_W-1:0] h_eff;
   logic [gpr_pkg::ROW_W-1:0] h_last;
   logic                      at_col_end;
   logic                      at_row_end;
   logic                      col_trig;
   logic                      row_trig;
   logic [CW-1:0]             cx;
   logic [gpr_pkg::ROW_W-1:0] cy;

   logic advance;
   logic accept;

   gpr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // effective geometry: width between MIN_DIM and what the line memory holds, height at least MIN_DIM
   always_comb begin
      w_raw = WX'(cfg.width);
      if (w_raw < WX'(gpr_pkg::MIN_DIM)) begin
         w_eff = WE'(gpr_pkg::MIN_DIM);
      end else if (w_raw > WX'(MAX_WIDTH)) begin
         w_eff = WE'(MAX_WIDTH);
      end else begin
         w_eff = WE'(w_raw);
      end
      w_last = CW'(w_eff - WE'(1));
      if (cfg.height < gpr_pkg::SRC_HEIGHT_W'(gpr_pkg::MIN_DIM)) begin
         h_eff = gpr_pkg::ROW_W'(gpr_pkg::MIN_DIM);
      end else begin
         h_eff = gpr_pkg::ROW_W'(cfg.height);
      end
      h_last = h_eff - gpr_pkg::ROW_W'(1);
   end

   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;
   assign accept    = req.valid && advance;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == w_last) begin
            col_in = '0;
            row_in = (row_ff == h_last) ? '0 : row_ff + gpr_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // window centre and output trigger for the pixel at (col, row)
   always_comb begin
      at_col_end = (col_ff == w_last);
      at_row_end = (row_ff == h_last);
      pos_info.last_c_even = at_col_end & ~w_eff[0];
      pos_info.last_r_even = at_row_end & ~h_eff[0];
      col_trig = ((col_ff >= CW'(2)) && !col_ff[0]) || pos_info.last_c_even;
      row_trig = ((row_ff >= gpr_pkg::ROW_W'(2)) && !row_ff[0]) || pos_info.last_r_even;
      cx = pos_info.last_c_even ? col_ff - CW'(1) : col_ff - CW'(2);
      cy = pos_info.last_r_even ? row_ff - gpr_pkg::ROW_W'(1)
                                : row_ff - gpr_pkg::ROW_W'(2);
      pos_info.emit  = col_trig & row_trig;
      pos_info.done  = at_col_end & at_row_end;
      pos_info.out_x = gpr_pkg::OUT_X_W'(cx[CW-1:1]);
      pos_info.out_y = gpr_pkg::OUT_Y_W'(cy[gpr_pkg::ROW_W-1:1]);
      pos_info.r_lo  = row_ff[gpr_pkg::SLOT_W-1:0];
      pos_info.r_min = (row_ff >= gpr_pkg::ROW_W'(gpr_pkg::OFS_MAX)) ? gpr_pkg::OFS_MAX
                                                               : row_ff[gpr_pkg::OFS_W-1:0];
      pos_info.c_min = (col_ff >= CW'(gpr_pkg::OFS_MAX)) ? gpr_pkg::OFS_MAX
                                                         : gpr_pkg::OFS_W'(col_ff);
   end

   gpr_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .advance  (advance),
      .col_addr (col_ff),
      .pixel    (req.pixel),
      .pos_info (pos_info),
      .s2_valid (s2_valid),
      .s2_vsum  (s2_vsum),
      .s2_info  (s2_info)
   );

   gpr_hsum u_hsum (
      .clock    (clock),
      .reset    (reset),
      .restart  (cfg.restart),
      .advance  (advance),
      .s2_valid (s2_valid),
      .s2_vsum  (s2_vsum),
      .s2_info  (s2_info),
      .rsp      (rsp)
   );

endmodule

// File: design/gpr_checker.sv
// ----------------------------------------------------------------------------
// gpr_checker
// Port-level checks on the reduce stage, bound to the top level.
// ----------------------------------------------------------------------------
module gpr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [gpr_pkg::PIXEL_W-1:0] rsp_out_pixel,
   input logic [gpr_pkg::OUT_X_W-1:0] rsp_out_x,
   input logic [gpr_pkg::OUT_Y_W-1:0] rsp_out_y,
   input logic                        rsp_frame_done
);

   // no result word right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   // intake only pauses behind a stalled result word
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled with no pending result word");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_out_pixel) && $stable(rsp_out_x) &&
                                     $stable(rsp_out_y) && $stable(rsp_frame_done)))
      else $error("result word changed while stalled");

   // req_valid is part of the watched port set
   a_ready_known: assert property (@(posedge clock) disable iff (reset)
      req_valid |-> (req_ready == (!rsp_valid || rsp_ready)))
      else $error("input ready does not follow output stall");

endmodule

bind gaussian_pyramid_reduce gpr_checker u_gpr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_out_pixel  (rsp.out_pixel),
   .rsp_out_x      (rsp.out_x),
   .rsp_out_y      (rsp.out_y),
   .rsp_frame_done (rsp.frame_done)
);

// File: tb/gpr_reduce_checker.sv
// ----------------------------------------------------------------------------
// gpr_reduce_checker
// Watches the pixel, result and register ports of the pyramid reduce stage,
// keeps its own copy of the line stores, column history and raster position,
// and predicts every reduced pixel word. Each result word is compared with
// the oldest prediction. Register read data is checked against the values
// last written.
// ----------------------------------------------------------------------------
module gpr_reduce_checker
   import gpr_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   gpr_req_if                    req,
   gpr_rsp_if                    rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int unsigned           reduced_pending,
   output int unsigned           failures
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [OUT_X_W-1:0] x;
      logic [OUT_Y_W-1:0] y;
      logic               done;
   } reduced_word_type;

   reduced_word_type        reduced_q[$];
   logic [PIXEL_W-1:0]      row_store [SLOTS][MAX_WIDTH];
   logic [VSUM_W-1:0]       col_hist [SLOTS];
   logic [SRC_WIDTH_W-1:0]  cfg_width;
   logic [SRC_HEIGHT_W-1:0] cfg_height;
   int                      src_col;
   int                      src_row;
   int unsigned             fail_tally;

   initial begin
      fail_tally = 0;
   end

   function automatic int unsigned binomial_weight(input int k);
      case (k)
         0, 4: return 1;
         1, 3: return 4;
         default: return 6;
      endcase
   endfunction

   function automatic void log_failure(input string msg);
      fail_tally++;
      if (fail_tally <= 10) $display("%t  %s", $realtime, msg);
   endfunction

   // vertical 5-tap over the row stores, then horizontal 5-tap over history
   task automatic reduce_pixel(input logic [PIXEL_W-1:0] p);
      int               w;
      int               h;
      int               c;
      int               r;
      int               cy;
      int               cx;
      int               q;
      bit               row_hit;
      bit               col_hit;
      int unsigned      vsum;
      int unsigned      hsum;
      int unsigned      v;
      reduced_word_type word;
      w = cfg_width;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = cfg_height;
      if (h < MIN_DIM) h = MIN_DIM;
      c = src_col;
      r = src_row;
      row_hit = (r >= 2 && r % 2 == 0) || (r == h - 1 && h % 2 == 0);
      col_hit = (c >= 2 && c % 2 == 0) || (c == w - 1 && w % 2 == 0);
      // last row/column of an even size: window centred one step later
      cy = (r == h - 1 && h % 2 == 0) ? r - 1 : r - 2;
      cx = (c == w - 1 && w % 2 == 0) ? c - 1 : c - 2;
      vsum = 0;
      for (int k = 0; k < TAPS; k++) begin
         q = cy - 2 + k;
         if (q < 0) q = 0;
         if (q > r) q = r;
         v = (q == r) ? p : row_store[q & 3][c];
         vsum += v * binomial_weight(k);
      end
      row_store[r & 3][c] = p;
      if (row_hit && col_hit) begin
         hsum = 0;
         for (int k = 0; k < TAPS; k++) begin
            q = cx - 2 + k;
            if (q < 0) q = 0;
            if (q > c) q = c;
            v = (q == c) ? vsum : col_hist[(c - 1 - q) & 3];
            hsum += v * binomial_weight(k);
         end
         word.pixel = PIXEL_W'(hsum >> 8);
         word.x     = OUT_X_W'(cx >> 1);
         word.y     = OUT_Y_W'(cy >> 1);
         word.done  = (c == w - 1 && r == h - 1);
         reduced_q.push_back(word);
      end
      col_hist[3] = col_hist[2];
      col_hist[2] = col_hist[1];
      col_hist[1] = col_hist[0];
      col_hist[0] = VSUM_W'(vsum);
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      src_col = c;
      src_row = r;
   endtask

   always @(posedge clock) begin
      reduced_word_type       got;
      reduced_word_type       want;
      logic [CSR_DATA_W-1:0]  reg_value;
      if (reset) begin
         cfg_width  = WIDTH_RESET;
         cfg_height = HEIGHT_RESET;
         src_col    = 0;
         src_row    = 0;
         for (int i = 0; i < SLOTS; i++) col_hist[i] = '0;
         reduced_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == REG_SRC_WIDTH) cfg_width = csr_pwdata[SRC_WIDTH_W-1:0];
               else cfg_height = csr_pwdata[SRC_HEIGHT_W-1:0];
               // any register write restarts the frame
               src_col = 0;
               src_row = 0;
               for (int i = 0; i < SLOTS; i++) col_hist[i] = '0;
            end else begin
               reg_value = (csr_paddr[2] == REG_SRC_WIDTH) ? CSR_DATA_W'(cfg_width)
                                                          : CSR_DATA_W'(cfg_height);
               if (csr_prdata !== reg_value)
                  log_failure($sformatf("register read at %0d: expected %0d, got %0d",
                                        csr_paddr, reg_value, csr_prdata));
            end
         end
         if (req.valid && req.ready) reduce_pixel(req.pixel);
         if (rsp.valid && rsp.ready) begin
            got.pixel = rsp.out_pixel;
            got.x     = rsp.out_x;
            got.y     = rsp.out_y;
            got.done  = rsp.frame_done;
            if (reduced_q.size() == 0) begin
               log_failure($sformatf("unexpected word: pixel=%0d x=%0d y=%0d done=%0b",
                                     got.pixel, got.x, got.y, got.done));
            end else begin
               want = reduced_q.pop_front();
               if (got.pixel !== want.pixel || got.x !== want.x || got.y !== want.y ||
                   got.done !== want.done)
                  log_failure($sformatf({"word mismatch: expected pixel=%0d x=%0d y=%0d ",
                                         "done=%0b, got pixel=%0d x=%0d y=%0d done=%0b"},
                                        want.pixel, want.x, want.y, want.done,
                                        got.pixel, got.x, got.y, got.done));
            end
         end
      end
      reduced_pending <= reduced_q.size();
      failures        <= fail_tally;
   end

endmodule

// File: tb/tb_gaussian_pyramid_reduce.sv
// ----------------------------------------------------------------------------
// tb_gaussian_pyramid_reduce
// Drives source pixel frames into the reduce stage under a range of image
// sizes, saturating ones included, with random gaps on both handshakes, a
// long result stall, and drains between register updates. Checking is done
// by gpr_reduce_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_gaussian_pyramid_reduce;
   timeunit 1ns;
   timeprecision 1ps;
   import gpr_pkg::*;

   localparam int MAX_WIDTH     = 1024;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_LIMIT    = 4000;
   localparam int RANDOM_ITEMS  = 200;
   localparam int RANDOM_PHASES = 3;

   typedef enum int {FILL_RANDOM, FILL_WHITE, FILL_BLACK, FILL_EXTREMES} fill_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int unsigned           reduced_pending;
   int unsigned           failures;
   bit                    hold_rsp;
   bit                    calm;

   gpr_req_if req_ch ();
   gpr_rsp_if rsp_ch ();

   gaussian_pyramid_reduce #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   gpr_reduce_checker #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .reduced_pending(reduced_pending),
      .failures       (failures)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly no gap, some short, a few long
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic csr_access(input logic idx, input logic wr, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(input int w, input int h);
      csr_access(REG_SRC_WIDTH, 1'b1, CSR_DATA_W'(w));
      csr_access(REG_SRC_HEIGHT, 1'b1, CSR_DATA_W'(h));
      csr_access(REG_SRC_WIDTH, 1'b0, '0);
      csr_access(REG_SRC_HEIGHT, 1'b0, '0);
   endtask

   task automatic send_pixel(input logic [PIXEL_W-1:0] p);
      int gap;
      gap = calm ? 0 : idle_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pixel <= p;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic stream_pixels(input int n, input fill_mode_type mode);
      logic [PIXEL_W-1:0] p;
      for (int i = 0; i < n; i++) begin
         case (mode)
            FILL_WHITE:    p = '1;
            FILL_BLACK:    p = '0;
            FILL_EXTREMES: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:       p = PIXEL_W'($urandom_range(0, 255));
         endcase
         send_pixel(p);
      end
   endtask

   // wait out every expected word, then let any result-free pixel clear the pipe
   task automatic finish_phase();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (reduced_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned   random_items;
      int            phase_idx;
      int            w;
      int            h;
      int            fw;
      int            fh;
      int            npix;
      fill_mode_type mode;
      req_ch.valid <= 1'b0;
      req_ch.pixel <= '0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      reset        <= 1'b1;
      hold_rsp     = 1'b0;
      calm         = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry, two full rows and the start of the first output row
      stream_pixels(2 * WIDTH_RESET + 12, FILL_RANDOM);
      finish_phase();

      // smallest frame at full scale, then wrap into a black frame
      set_geometry(MIN_DIM, MIN_DIM);
      calm = 1'b1;
      stream_pixels(16, FILL_WHITE);
      stream_pixels(8, FILL_BLACK);
      finish_phase();

      random_items = 0;
      phase_idx    = 0;
      while (phase_idx < RANDOM_PHASES || random_items < RANDOM_ITEMS) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 12);
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 9);
         set_geometry(w, h);
         fw = (w < MIN_DIM) ? MIN_DIM : w;
         fh = (h < MIN_DIM) ? MIN_DIM : h;
         npix = fw * fh * $urandom_range(1, 2);
         // partial frames end in a mid-frame restart
         if ($urandom_range(0, 9) < 3) npix = $urandom_range(1, npix);
         if (phase_idx == 2) npix = 3 * fw * fh;
         calm = ($urandom_range(0, 4) == 0);
         mode = ($urandom_range(0, 9) == 0) ? FILL_EXTREMES : FILL_RANDOM;
         if (phase_idx == 2) hold_rsp = 1'b1;
         stream_pixels(npix, mode);
         finish_phase();
         random_items += npix;
         phase_idx++;
      end

      // tallest height over a few rows
      calm = 1'b0;
      set_geometry(MIN_DIM, 4095);
      stream_pixels(48, FILL_RANDOM);
      finish_phase();

      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("** gaussian_pyramid_reduce: PASSED **");
      end else begin
         $display("** gaussian_pyramid_reduce: FAILED **");
      end
      $finish;
   end

   // result side: random backpressure, calm stretches, one long hold
   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (calm) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else begin
            n = idle_gap();
            if (n > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // watchdog: too long with no word, result or register access
   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             csr_psel) idle = 0;
         else idle++;
      end
      $display("** gaussian_pyramid_reduce: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
design/gpr_pkg.sv
design/gpr_req_if.sv
design/gpr_rsp_if.sv
design/gpr_csr.sv
design/gpr_line_store.sv
design/gpr_hsum.sv
design/gaussian_pyramid_reduce.sv
design/gpr_checker.sv
tb/gpr_reduce_checker.sv
tb/tb_gaussian_pyramid_reduce.sv
